FILE: hw/rtl/ptec_pkg.sv
// ----------------------------------------------------------------------------
// ptec_pkg
// Shared widths, codes and types for the periodic timer expiry counter.
// ----------------------------------------------------------------------------
package ptec_pkg;

   localparam int TIME_W   = 64;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;

   // transaction kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_OBSERVE = 2'd0,
      KIND_ARM     = 2'd1,
      KIND_READ    = 2'd2,
      KIND_SPARE   = 2'd3
   } ptec_kind_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_WOULD_BLOCK = 2'd1,
      STATUS_MUST_WAIT   = 2'd2,
      STATUS_UNUSED      = 2'd3
   } ptec_status_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PREP = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } ptec_state_type;

   // divider handshake status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } ptec_div_stat_type;

endpackage

FILE: hw/rtl/periodic_timer_expiry_counter_top.sv
// ----------------------------------------------------------------------------
// periodic_timer_expiry_counter_top
// Timer with deadline and period; reports and consumes pending expiries.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_stall  | kind, now, arm value/interval/absolute
//  rsp_    | out       | rsp_valid/rsp_stall  | status, expiries, ready, remaining, prior period
//  csr_    | in        | csr_valid/csr_ready  | nonblocking flag
//
//  a periodic timer that is due goes through ST_PREP, the bit-serial divider
//  (64 steps plus hand-over) and ST_DIV to ST_DONE, where the result is
//  registered; any other transaction goes from ST_PREP straight to ST_DONE.
//  the next request is taken back in ST_IDLE. a stalled result holds the
//  sequencer in its last state. the new deadline after a read is
//  now - remainder + period, so no multiply. reset clears all timer state.
// ----------------------------------------------------------------------------
module periodic_timer_expiry_counter_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ptec_pkg::KIND_W-1:0]      req_kind,
   input  logic [ptec_pkg::TIME_W-1:0]      req_now_ns,
   input  logic [ptec_pkg::TIME_W-1:0]      req_arm_value_ns,
   input  logic [ptec_pkg::TIME_W-1:0]      req_arm_interval_ns,
   input  logic                             req_arm_absolute,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ptec_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ptec_pkg::TIME_W-1:0]      rsp_expiries,
   output logic                             rsp_ready_res,
   output logic [ptec_pkg::TIME_W-1:0]      rsp_remaining_ns,
   output logic [ptec_pkg::TIME_W-1:0]      rsp_prior_period_ns,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_wdata
);
   import ptec_pkg::*;

   localparam int W = TIME_W;

   ptec_state_type    state_ff, state_in;
   ptec_div_stat_type div_stat;
   logic              div_start;
   logic [W-1:0]      div_quo, div_rem;

   // timer state
   logic [W-1:0]      deadline_ff, deadline_in;
   logic [W-1:0]      period_ff, period_in;
   logic              nonblk_ff;

   // captured request
   ptec_kind_type     kind_ff;
   logic [W-1:0]      now_ff, aval_ff, aint_ff;
   logic              aabs_ff;

   // per transaction working values
   logic [W-1:0]      cnt_ff, cnt_in;
   logic [W-1:0]      base_ff, base_in;
   logic [W-1:0]      remain_ff, remain_in;
   logic [W-1:0]      oldper_ff, oldper_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   ptec_status_type   status_ff, status_in;
   logic [W-1:0]      exp_ff, exp_in;
   logic [W-1:0]      rem_out_ff, oldint_out_ff;

   logic              accept;
   logic              out_free;
   logic              armed;
   logic              due;
   logic [W-1:0]      sum_a, sum_b, sum;

   assign accept   = req_valid & ~req_stall;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign armed    = (deadline_ff != '0);
   assign due      = armed & (now_ff >= deadline_ff);

   // divider for the elapsed time over the period
   ptec_div #(
      .DIV_W (W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (now_ff - deadline_ff),
      .divisor   (period_ff),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // deadline adder operands: relative arm or read on a periodic timer
   always_comb begin
      if (kind_ff == KIND_ARM) begin
         sum_a = now_ff;
         sum_b = aval_ff;
      end else begin
         sum_a = base_ff;
         sum_b = period_ff;
      end
   end
   assign sum = sum_a + sum_b;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      cnt_in       = cnt_ff;
      base_in      = base_ff;
      remain_in    = remain_ff;
      oldper_in    = oldper_ff;
      deadline_in  = deadline_ff;
      period_in    = period_ff;
      status_in    = status_ff;
      exp_in       = exp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_PREP;
         end
         ST_PREP: begin
            remain_in = (armed && (deadline_ff > now_ff)) ? deadline_ff - now_ff : '0;
            oldper_in = period_ff;
            cnt_in    = due ? W'(1) : '0;
            if (due && (period_ff != '0)) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               cnt_in   = div_quo + W'(1);
               base_in  = now_ff - div_rem;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_OK;
               exp_in       = cnt_ff;
               case (kind_ff)
                  KIND_ARM: begin
                     if (aval_ff == '0) begin
                        deadline_in = '0;
                        period_in   = '0;
                     end else begin
                        deadline_in = aabs_ff ? aval_ff : sum;
                        period_in   = aint_ff;
                     end
                  end
                  KIND_READ: begin
                     if (cnt_ff != '0) begin
                        deadline_in = (period_ff == '0) ? '0 : sum;
                     end else if (nonblk_ff || !armed) begin
                        status_in = STATUS_WOULD_BLOCK;
                     end else begin
                        status_in = STATUS_MUST_WAIT;
                     end
                  end
                  default: begin
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         deadline_ff  <= '0;
         period_ff    <= '0;
         nonblk_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         deadline_ff  <= deadline_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) nonblk_ff <= csr_wdata;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= ptec_kind_type'(req_kind);
         now_ff  <= req_now_ns;
         aval_ff <= req_arm_value_ns;
         aint_ff <= req_arm_interval_ns;
         aabs_ff <= req_arm_absolute;
      end
   end

   // working values and result payload
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      base_ff   <= base_in;
      remain_ff <= remain_in;
      oldper_ff <= oldper_in;
      status_ff <= status_in;
      exp_ff    <= exp_in;
      if (state_ff == ST_DONE && out_free) begin
         rem_out_ff    <= remain_ff;
         oldint_out_ff <= oldper_ff;
      end
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_expiries        = exp_ff;
   assign rsp_ready_res       = (exp_ff != '0);
   assign rsp_remaining_ns    = rem_out_ff;
   assign rsp_prior_period_ns = oldint_out_ff;

endmodule

FILE: hw/rtl/ptec_div.sv
// ----------------------------------------------------------------------------
// ptec_div
// Restoring divider, one quotient bit per cycle through one shared subtractor.
// ----------------------------------------------------------------------------
module ptec_div #(
   parameter int DIV_W = ptec_pkg::TIME_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DIV_W-1:0]              dividend,
   input  logic [DIV_W-1:0]              divisor,
   output ptec_pkg::ptec_div_stat_type   stat,
   output logic [DIV_W-1:0]              quotient,
   output logic [DIV_W-1:0]              remainder
);
   import ptec_pkg::*;

   localparam int CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;

   logic [DIV_W:0]   shifted;
   logic [DIV_W:0]   trial;
   logic             fits;

   // shared subtractor: shifted partial remainder minus divisor
   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign trial   = shifted - {1'b0, dsr_ff};
   assign fits    = ~trial[DIV_W];

   // step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: hw/rtl/ptec_checker.sv
// ----------------------------------------------------------------------------
// ptec_checker
// Port-level checks on the timer block, bound to the top level.
// ----------------------------------------------------------------------------
module ptec_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [ptec_pkg::STATUS_W-1:0]    rsp_status,
   input logic [ptec_pkg::TIME_W-1:0]      rsp_expiries,
   input logic                             rsp_ready_res
);
   import ptec_pkg::*;

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   // ready flag tracks the expiry count
   a_ready_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ready_res == (rsp_expiries != '0)))
      else $error("ready flag disagrees with expiries");

   // a failed read reports no expiries
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_WOULD_BLOCK || rsp_status == STATUS_MUST_WAIT))
      |-> (rsp_expiries == '0))
      else $error("failed read shows expiries");

   // one transaction in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while busy");

   // never an undefined status code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != STATUS_UNUSED))
      else $error("undefined status code");

endmodule

bind periodic_timer_expiry_counter_top ptec_checker u_ptec_checker (.*);
